### hdl/arp_request_responder_top_defines.svh
// Assertion macros shared by the ARP responder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/arp_pkg.sv
// Types, constants and byte helpers for the ARP responder.
// No dependencies.
package arp_pkg;

    localparam logic [5:0] REPLY_LEN = 6'd42;
    localparam logic [5:0] LAST_POS  = 6'd41;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd1;

    // captured request fields, one queue entry per pending reply
    typedef struct packed {
        logic [47:0] sha;
        logic [31:0] spa;
        logic [7:0]  hlen;
        logic [7:0]  plen;
    } t_reply_rec;

    typedef struct packed {
        logic rd_en;
        logic pop;
    } t_rq_ctl;

    typedef struct packed {
        logic nonempty;
        logic full;
    } t_rq_stat;

    // byte k of a MAC, first wire byte first
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = mac[47:40];
            3'd1: b = mac[39:32];
            3'd2: b = mac[31:24];
            3'd3: b = mac[23:16];
            3'd4: b = mac[15:8];
            3'd5: b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0: b = ip[31:24];
            2'd1: b = ip[23:16];
            2'd2: b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

endpackage

### hdl/arp_parse.sv
// Request parser: byte counter, field checks, capture of sender and size fields.
// Depends on arp_pkg.
module arp_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic [31:0]           i_own_ip,
    output logic                  o_push,
    output arp_pkg::t_reply_rec   o_rec
);

    logic [5:0]  r_pos;
    logic        r_qual;
    logic [47:0] r_sha;
    logic [31:0] r_spa;
    logic [7:0]  r_hlen;
    logic [7:0]  r_plen;

    logic [5:0]  n_pos;
    logic        n_qual;
    logic        chk;
    logic        in_hdr;

    always_comb begin
        chk = 1'b1;
        case (r_pos)
            6'd12: chk = (i_byte == arp_pkg::ETHERTYPE_ARP[15:8]);
            6'd13: chk = (i_byte == arp_pkg::ETHERTYPE_ARP[7:0]);
            6'd14: chk = (i_byte == arp_pkg::HTYPE_ETH[15:8]);
            6'd15: chk = (i_byte == arp_pkg::HTYPE_ETH[7:0]);
            6'd16: chk = (i_byte == arp_pkg::PTYPE_IPV4[15:8]);
            6'd17: chk = (i_byte == arp_pkg::PTYPE_IPV4[7:0]);
            6'd20: chk = (i_byte == arp_pkg::OPER_REQUEST[15:8]);
            6'd21: chk = (i_byte == arp_pkg::OPER_REQUEST[7:0]);
            6'd38, 6'd39, 6'd40, 6'd41:
                chk = (i_byte == arp_pkg::ip_byte(i_own_ip, 2'(r_pos - 6'd38)));
            default: chk = 1'b1;
        endcase
    end

    assign in_hdr = (r_pos < arp_pkg::REPLY_LEN);
    assign n_pos  = in_hdr ? r_pos + 6'd1 : r_pos;
    assign n_qual = r_qual & (chk | ~in_hdr);
    assign o_push = i_accept & i_last & n_qual & (n_pos == arp_pkg::REPLY_LEN);

    // captures are complete by byte 32, so registers feed the queue directly
    assign o_rec = '{sha: r_sha, spa: r_spa, hlen: r_hlen, plen: r_plen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 6'd0;
            r_qual <= 1'b1;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos  <= 6'd0;
                r_qual <= 1'b1;
            end else begin
                r_pos  <= n_pos;
                r_qual <= n_qual;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_pos == 6'd18) begin
                r_hlen <= i_byte;
            end else if (r_pos == 6'd19) begin
                r_plen <= i_byte;
            end else if (r_pos >= 6'd22 && r_pos < 6'd28) begin
                r_sha <= {r_sha[39:0], i_byte};
            end else if (r_pos >= 6'd28 && r_pos < 6'd32) begin
                r_spa <= {r_spa[23:0], i_byte};
            end
        end
    end

endmodule

### hdl/arp_rq.sv
// Reply queue: synchronous memory of captured request records.
// Depends on arp_pkg and the assertion macro header.
`include "arp_request_responder_top_defines.svh"

module arp_rq #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  arp_pkg::t_reply_rec   i_wr_rec,
    input  arp_pkg::t_rq_ctl      i_ctl,
    output arp_pkg::t_rq_stat     o_stat,
    output arp_pkg::t_reply_rec   o_rd_rec
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    arp_pkg::t_reply_rec mem [DEPTH];

    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    arp_pkg::t_reply_rec r_rd_data;

    assign o_stat.nonempty = (r_count != '0);
    assign o_stat.full     = (r_count == FULL_CNT);
    assign o_rd_rec        = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_wr_rec;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_ctl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ARP_ASSERT_NOW(a_no_push_full, o_stat.full, !i_push, "push into full reply queue")
    `ARP_ASSERT_NOW(a_no_pop_empty, i_ctl.pop || i_ctl.rd_en, o_stat.nonempty,
        "reply queue read while empty")
    `ARP_ASSERT_NEXT(a_count_up, i_push && !i_ctl.pop, r_count == $past(r_count) + 1'b1,
        "reply queue count lost a push")

endmodule

### hdl/arp_ser.sv
// Reply serializer: walks 42 reply bytes from a queued record into an output register.
// Depends on arp_pkg and the assertion macro header.
`include "arp_request_responder_top_defines.svh"

module arp_ser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arp_pkg::t_rq_stat     i_stat,
    input  arp_pkg::t_reply_rec   i_rec,
    output arp_pkg::t_rq_ctl      o_ctl,
    input  logic [31:0]           i_own_ip,
    input  logic [47:0]           i_own_mac,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_last
);

    logic       r_loaded;
    logic [5:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       adv;
    logic       emit;
    logic       at_end;
    logic [7:0] n_byte;

    assign adv    = ~r_out_valid | i_ready;
    assign emit   = adv & r_loaded;
    assign at_end = (r_pos == arp_pkg::LAST_POS);

    assign o_ctl.rd_en = ~r_loaded & i_stat.nonempty;
    assign o_ctl.pop   = emit & at_end;

    always_comb begin
        if (r_pos < 6'd6) begin
            n_byte = arp_pkg::mac_byte(i_rec.sha, r_pos[2:0]);
        end else if (r_pos < 6'd12) begin
            n_byte = arp_pkg::mac_byte(i_own_mac, 3'(r_pos - 6'd6));
        end else if (r_pos < 6'd22) begin
            case (r_pos)
                6'd12:   n_byte = arp_pkg::ETHERTYPE_ARP[15:8];
                6'd13:   n_byte = arp_pkg::ETHERTYPE_ARP[7:0];
                6'd14:   n_byte = arp_pkg::HTYPE_ETH[15:8];
                6'd15:   n_byte = arp_pkg::HTYPE_ETH[7:0];
                6'd16:   n_byte = arp_pkg::PTYPE_IPV4[15:8];
                6'd17:   n_byte = arp_pkg::PTYPE_IPV4[7:0];
                6'd18:   n_byte = i_rec.hlen;
                6'd19:   n_byte = i_rec.plen;
                6'd20:   n_byte = arp_pkg::OPER_REPLY[15:8];
                default: n_byte = arp_pkg::OPER_REPLY[7:0];
            endcase
        end else if (r_pos < 6'd28) begin
            n_byte = arp_pkg::mac_byte(i_own_mac, 3'(r_pos - 6'd22));
        end else if (r_pos < 6'd32) begin
            n_byte = arp_pkg::ip_byte(i_own_ip, 2'(r_pos - 6'd28));
        end else if (r_pos < 6'd38) begin
            n_byte = arp_pkg::mac_byte(i_rec.sha, 3'(r_pos - 6'd32));
        end else begin
            n_byte = arp_pkg::ip_byte(i_rec.spa, 2'(r_pos - 6'd38));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_pos       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.rd_en) begin
                r_loaded <= 1'b1;
            end else if (o_ctl.pop) begin
                r_loaded <= 1'b0;
            end
            if (emit) begin
                r_pos <= at_end ? 6'd0 : r_pos + 6'd1;
            end
            if (adv) begin
                r_out_valid <= r_loaded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= n_byte;
            r_out_last <= at_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    `ARP_ASSERT_NOW(a_pos_idle, !r_loaded, r_pos == 6'd0, "byte index off zero with no record")
    `ARP_ASSERT_NEXT(a_last_wraps, emit && at_end, !r_loaded && r_pos == 6'd0,
        "record not released after final reply byte")

endmodule

### hdl/arp_request_responder_top.sv
// Top level of the Ethernet ARP request responder.
// Depends on arp_pkg, arp_parse, arp_rq and arp_ser.
//
// Receives an Ethernet frame one byte per item (i_frame_last on the final byte)
// and, when the frame is an ARP request (ethertype 0x0806, htype 1, ptype 0x0800,
// opcode 1) of at least 42 bytes whose target IP equals own_ip, sends a 42-byte
// ARP reply: destination = requester MAC, source = own_mac, sizes echoed,
// opcode 2, sender = (own_mac, own_ip), target = requester MAC/IP. Bytes past
// the 42nd are ignored. Frame bytes are taken at one per clock while the reply
// queue is not full. Each qualifying frame stores one record (requester MAC/IP
// and size bytes) in a reply queue memory of RQ_DEPTH entries; o_frame_ready
// drops only while that queue is full. A reply first reads its record from the
// queue memory, then sends 42 bytes from the output register.
// Registers: index 0 = own_ip (i_cfg_data[31:0]), index 1 = own_mac
// (i_cfg_data[47:0]); other indexes are ignored. Writes are taken every cycle
// and are expected only while no reply is pending.
module arp_request_responder_top #(
    parameter int unsigned RQ_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // frame input
    input  logic                           i_frame_valid,
    output logic                           o_frame_ready,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_frame_last,
    // reply output
    output logic                           o_reply_valid,
    input  logic                           i_reply_ready,
    output logic [7:0]                     o_reply_byte,
    output logic                           o_reply_last,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [arp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [arp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;

    logic                frame_acc;
    logic                push;
    arp_pkg::t_reply_rec wr_rec;
    arp_pkg::t_reply_rec rd_rec;
    arp_pkg::t_rq_ctl    rq_ctl;
    arp_pkg::t_rq_stat   rq_stat;

    assign o_cfg_ready   = 1'b1;
    assign o_frame_ready = ~rq_stat.full;
    assign frame_acc     = i_frame_valid & o_frame_ready;

    // register file; reset values are the default address pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= 32'h0A01_0A2A;
            r_own_mac <= 48'h000C_296D_5025;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arp_pkg::CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                arp_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // header checks and capture
    arp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (frame_acc),
        .i_byte   (i_frame_byte),
        .i_last   (i_frame_last),
        .i_own_ip (r_own_ip),
        .o_push   (push),
        .o_rec    (wr_rec)
    );

    // pending replies
    arp_rq #(
        .DEPTH (RQ_DEPTH)
    ) u_rq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_rec (wr_rec),
        .i_ctl    (rq_ctl),
        .o_stat   (rq_stat),
        .o_rd_rec (rd_rec)
    );

    // reply byte generation
    arp_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stat    (rq_stat),
        .i_rec     (rd_rec),
        .o_ctl     (rq_ctl),
        .i_own_ip  (r_own_ip),
        .i_own_mac (r_own_mac),
        .o_valid   (o_reply_valid),
        .i_ready   (i_reply_ready),
        .o_byte    (o_reply_byte),
        .o_last    (o_reply_last)
    );

endmodule

### tb/tb_arp_request_responder_top.sv
`timescale 1ns / 100ps
// Testbench for arp_request_responder_top: sends ARP requests, broken, short and noise frames,
// predicts each 42-byte ARP reply and checks every reply item against it.
// Depends on arp_pkg and arp_request_responder_top.
module tb_arp_request_responder_top;

    // byte offsets inside an Ethernet ARP frame
    localparam int unsigned POS_ETHERTYPE = 12;
    localparam int unsigned POS_HTYPE     = 14;
    localparam int unsigned POS_PTYPE     = 16;
    localparam int unsigned POS_HLEN      = 18;
    localparam int unsigned POS_PLEN      = 19;
    localparam int unsigned POS_OPER      = 20;
    localparam int unsigned POS_SHA       = 22;
    localparam int unsigned POS_SPA       = 28;
    localparam int unsigned POS_TPA       = 38;

    localparam int unsigned REPLY_HOLD_CYCLES = 1000; // long sink stall, fills the reply queue
    localparam int unsigned SETTLE_CYCLES     = 60;   // longer than one whole reply

    // indexes that decode to no register
    localparam logic [arp_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
    localparam logic [arp_pkg::CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;

    // Tracks the responder state per accepted frame byte and holds the reply bytes due.
    class arp_reply_predictor;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        int unsigned rx_pos;
        logic [47:0] req_mac;
        logic [31:0] req_ip;
        logic [7:0]  req_hlen;
        logic [7:0]  req_plen;
        bit          rx_match;
        logic [8:0]  reply_bytes_due[$]; // {last, byte}
        int          mismatches;

        function new();
            ip_addr    = 32'h0A01_0A2A;
            mac_addr   = 48'h000C_296D_5025;
            rx_pos     = 0;
            req_mac    = '0;
            req_ip     = '0;
            req_hlen   = '0;
            req_plen   = '0;
            rx_match   = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [arp_pkg::CFG_IDX_W-1:0] idx,
                                logic [arp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                arp_pkg::CFG_OWN_IP:  ip_addr = data[31:0];
                arp_pkg::CFG_OWN_MAC: mac_addr = data[47:0];
                default: ;
            endcase
        endfunction

        function void take_frame_byte(logic [7:0] b, logic last);
            logic [79:0]  req_hdr;
            logic [335:0] reply;
            req_hdr = {arp_pkg::ETHERTYPE_ARP, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4,
                       16'h0000, arp_pkg::OPER_REQUEST};
            if (rx_pos < arp_pkg::REPLY_LEN) begin
                // size bytes are echoed, not checked
                if (rx_pos >= POS_ETHERTYPE && rx_pos < POS_SHA &&
                    rx_pos != POS_HLEN && rx_pos != POS_PLEN)
                    rx_match &= (b == req_hdr[8*(POS_SHA-1-rx_pos) +: 8]);
                else if (rx_pos >= POS_TPA)
                    rx_match &= (b == ip_addr[8*(arp_pkg::LAST_POS-rx_pos) +: 8]);
                if (rx_pos == POS_HLEN)
                    req_hlen = b;
                else if (rx_pos == POS_PLEN)
                    req_plen = b;
                else if (rx_pos >= POS_SHA && rx_pos < POS_SPA)
                    req_mac = {req_mac[39:0], b};
                else if (rx_pos >= POS_SPA && rx_pos < POS_SPA + 4)
                    req_ip = {req_ip[23:0], b};
                rx_pos++;
            end
            if (last) begin
                if (rx_match && rx_pos == arp_pkg::REPLY_LEN) begin
                    reply = {req_mac, mac_addr, arp_pkg::ETHERTYPE_ARP, arp_pkg::HTYPE_ETH,
                             arp_pkg::PTYPE_IPV4, req_hlen, req_plen, arp_pkg::OPER_REPLY,
                             mac_addr, ip_addr, req_mac, req_ip};
                    for (int k = 0; k < arp_pkg::REPLY_LEN; k++)
                        reply_bytes_due.push_back({k == arp_pkg::LAST_POS,
                                                   reply[8*(arp_pkg::LAST_POS-k) +: 8]});
                end
                rx_pos   = 0;
                rx_match = 1'b1;
            end
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("tb: mismatch: %s", what);
        endfunction

        function void check_reply_byte(logic [7:0] b, logic last);
            logic [8:0] due;
            if (reply_bytes_due.size() == 0) begin
                note_mismatch($sformatf("reply item with none due: byte %h last %b", b, last));
            end else begin
                due = reply_bytes_due.pop_front();
                if (b !== due[7:0])
                    note_mismatch($sformatf("reply byte: expected %h got %h", due[7:0], b));
                if (last !== due[8])
                    note_mismatch($sformatf("reply last: expected %b got %b", due[8], last));
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_frame_valid = 1'b0;
    logic [7:0]                     i_frame_byte = '0;
    logic                           i_frame_last = 1'b0;
    logic                           i_reply_ready = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [arp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [arp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_frame_ready;
    logic                           o_reply_valid;
    logic [7:0]                     o_reply_byte;
    logic                           o_reply_last;
    logic                           o_cfg_ready;

    arp_reply_predictor pred = new();

    bit idle_on = 1'b1;        // random gaps on both sides
    bit hold_req = 1'b0;       // asks the sink for one long stall
    bit frame_offering = 1'b0; // i_frame_valid is (about to be) high
    logic [7:0] frame_buf[$];  // bytes of the next frame to send

    arp_request_responder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (i_frame_valid),
        .o_frame_ready (o_frame_ready),
        .i_frame_byte  (i_frame_byte),
        .i_frame_last  (i_frame_last),
        .o_reply_valid (o_reply_valid),
        .i_reply_ready (i_reply_ready),
        .o_reply_byte  (o_reply_byte),
        .o_reply_last  (o_reply_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop; a correct run takes well under a tenth of this.
    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // Reply sink. Outputs are read right after the edge, before any NBA of that step lands,
    // so they hold the values the DUT presented at the edge. Ready is redecided every cycle:
    // short random stalls, or one long stall on request.
    initial begin : reply_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_reply_ready && o_reply_valid !== 1'b0)
                pred.check_reply_byte(o_reply_byte, o_reply_last);
            if (hold_left != 0) begin
                hold_left--;
            end else if (hold_req) begin
                hold_left = REPLY_HOLD_CYCLES;
                hold_req  = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 13);
            end
            i_reply_ready <= (hold_left == 0);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Offer one frame byte and return at the edge that takes it. Valid stays high on return,
    // so a following call either keeps it up or opens a gap first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            if (frame_offering)
                i_frame_valid <= 1'b0;
            frame_offering = 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_frame_valid  <= 1'b1;
        i_frame_byte   <= b;
        i_frame_last   <= last;
        frame_offering = 1'b1;
        do @(posedge i_clk); while (o_frame_ready !== 1'b1);
        pred.take_frame_byte(b, last);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_buf.size(); k++)
            send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // Well-formed request into frame_buf; unused MAC fields all ones or random,
    // tail = extra bytes past the 42nd.
    function automatic void build_request(input logic [47:0] sha, input logic [31:0] spa,
                                          input logic [31:0] tpa, input logic [7:0] hlen,
                                          input logic [7:0] plen, input bit unused_ones,
                                          input int tail);
        logic [335:0] req;
        logic [47:0]  dst;
        logic [47:0]  src;
        logic [47:0]  tha;
        dst = unused_ones ? 48'hFFFF_FFFF_FFFF : rand48();
        src = unused_ones ? 48'hFFFF_FFFF_FFFF : rand48();
        tha = unused_ones ? 48'hFFFF_FFFF_FFFF : rand48();
        req = {dst, src, arp_pkg::ETHERTYPE_ARP, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4,
               hlen, plen, arp_pkg::OPER_REQUEST, sha, spa, tha, tpa};
        frame_buf.delete();
        for (int k = 0; k < arp_pkg::REPLY_LEN; k++)
            frame_buf.push_back(req[8*(arp_pkg::LAST_POS-k) +: 8]);
        repeat (tail) frame_buf.push_back(8'($urandom));
    endfunction

    // Mostly good requests for our IP with random content; the rest have one checked
    // byte wrong, are cut short, or are plain noise.
    task automatic run_random_frames(input int count);
        int kind;
        int cut;
        int unsigned checked_pos[12] = '{POS_ETHERTYPE, POS_ETHERTYPE + 1, POS_HTYPE,
                                         POS_HTYPE + 1, POS_PTYPE, POS_PTYPE + 1, POS_OPER,
                                         POS_OPER + 1, POS_TPA, POS_TPA + 1, POS_TPA + 2,
                                         POS_TPA + 3};
        repeat (count) begin
            kind = $urandom_range(0, 99);
            build_request(rand48(), $urandom, pred.ip_addr, 8'($urandom), 8'($urandom), 1'b0,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
            if (kind >= 60 && kind < 75) begin
                cut = checked_pos[$urandom_range(0, 11)];
                frame_buf[cut] ^= 8'($urandom_range(1, 255));
            end else if (kind >= 75 && kind < 90) begin
                cut = $urandom_range(1, arp_pkg::LAST_POS);
                while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end else if (kind >= 90) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
            end
            send_frame();
        end
    endtask

    // Register write; valid stays up so writes can go back to back.
    task automatic write_reg(input logic [arp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        pred.write_reg(idx, data);
    endtask

    // Called right after the last accepted byte: drop valid, wait for every reply due,
    // then let a rejected frame finish inside the block before anything else happens.
    task automatic wait_replies_done();
        i_frame_valid  <= 1'b0;
        frame_offering = 1'b0;
        while (pred.reply_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset addresses. One-byte frames at both byte extremes, then a long request
        // with all-ones MACs, zero sender IP and extreme size bytes. The sender then
        // pauses until every reply is out.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        build_request(48'hFFFF_FFFF_FFFF, 32'h0, pred.ip_addr, 8'hFF, 8'h00, 1'b1, 3);
        send_frame();
        wait_replies_done();

        // All-ones addresses (own_ip with junk above bit 31, which the block must drop),
        // followed by writes to indexes that must be ignored; a partial index decode
        // would show up as changed reply fields.
        write_reg(arp_pkg::CFG_OWN_IP, {16'($urandom), 32'hFFFF_FFFF});
        write_reg(arp_pkg::CFG_OWN_MAC, '1);
        write_reg(CFG_SPARE_IDX, rand48());
        write_reg(CFG_TOP_IDX, '0);
        i_cfg_valid <= 1'b0;

        // Last stretch, no gaps on either side: the sink stalls for a long time while
        // requests stream in back to back, filling the reply queue until frame input
        // stalls. The first is an exact 42-byte request with the opposite field extremes.
        idle_on  = 1'b0;
        hold_req = 1'b1;
        build_request(48'h0, 32'hFFFF_FFFF, pred.ip_addr, 8'h00, 8'hFF, 1'b0, 0);
        send_frame();
        repeat (3) begin
            build_request(rand48(), $urandom, pred.ip_addr, 8'($urandom), 8'($urandom),
                          1'b0, 0);
            send_frame();
        end
        run_random_frames(1);
        wait_replies_done();

        if (pred.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
